FILE: hdl/sks_pkg.sv
// ----------------------------------------------------------------------------
// sks_pkg
// Shared types, constants and noise table for the six-axis Kalman smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package sks_pkg;

  localparam int CHANNELS  = 6;
  localparam int SAMPLE_W  = 32;
  localparam int CH_W      = 3;
  localparam int K_W       = 30;
  localparam int CNT_W     = 5;
  localparam int ADDR_W    = 6;
  localparam int DATA_W    = 64;
  localparam int NOISE_W   = 27;

  localparam logic [CNT_W-1:0]  DIV_LAST   = CNT_W'(K_W - 1);
  localparam logic [CH_W-1:0]   CH_LAST    = CH_W'(CHANNELS - 1);
  localparam logic [31:0]       PROC_NOISE = 32'd10737;
  localparam logic [30:0]       ONE_Q30    = 31'h4000_0000;
  localparam logic [63:0]       HALF_Q30   = 64'h2000_0000;
  localparam logic [31:0]       VAR_RESET  = 32'h4000_0000;

  localparam logic [2:0] REG_ENABLE    = 3'd0;
  localparam logic [2:0] REG_FLIMIT    = 3'd1;
  localparam logic [2:0] REG_TLIMIT    = 3'd2;
  localparam logic [2:0] REG_OFF_FXFY  = 3'd3;
  localparam logic [2:0] REG_OFF_FZTX  = 3'd4;
  localparam logic [2:0] REG_OFF_TYTZ  = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_MUL,
    ST_EST,
    ST_OUT,
    ST_DONE
  } sks_state_t;

  typedef struct packed {
    logic            load;
    logic            prep;
    logic            div_step;
    logic            mul;
    logic            upd_est;
    logic            upd_out;
    logic            out_load;
    logic [CH_W-1:0] ch;
  } sks_cmd_t;

  typedef struct packed {
    logic                                enable;
    logic [30:0]                         force_limit;
    logic [30:0]                         torque_limit;
    logic [CHANNELS-1:0][SAMPLE_W-1:0]   offset;
  } sks_cfg_t;

  function automatic logic [NOISE_W-1:0] meas_noise(input logic [CH_W-1:0] ch);
    logic [NOISE_W-1:0] r;
    case (ch)
      3'd0:    r = 27'd937802;
      3'd1:    r = 27'd1076705;
      3'd2:    r = 27'd85700330;
      3'd3:    r = 27'd56870;
      3'd4:    r = 27'd34518;
      3'd5:    r = 27'd15097;
      default: r = 27'd15097;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/sks_if.sv
// ----------------------------------------------------------------------------
// sks_if
// Valid/ready channels for input samples and filtered results.
// ----------------------------------------------------------------------------
`default_nettype none

interface sks_sample_if;
  import sks_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] force_x;
  logic signed [SAMPLE_W-1:0] force_y;
  logic signed [SAMPLE_W-1:0] force_z;
  logic signed [SAMPLE_W-1:0] torque_x;
  logic signed [SAMPLE_W-1:0] torque_y;
  logic signed [SAMPLE_W-1:0] torque_z;
  modport source (output valid, force_x, force_y, force_z, torque_x, torque_y, torque_z,
                  input ready);
  modport sink (input valid, force_x, force_y, force_z, torque_x, torque_y, torque_z,
                output ready);
endinterface

interface sks_result_if;
  import sks_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] filtered_force_x;
  logic signed [SAMPLE_W-1:0] filtered_force_y;
  logic signed [SAMPLE_W-1:0] filtered_force_z;
  logic signed [SAMPLE_W-1:0] filtered_torque_x;
  logic signed [SAMPLE_W-1:0] filtered_torque_y;
  logic signed [SAMPLE_W-1:0] filtered_torque_z;
  logic [CHANNELS-1:0]        over_range_mask;
  modport source (output valid, filtered_force_x, filtered_force_y, filtered_force_z,
                  filtered_torque_x, filtered_torque_y, filtered_torque_z,
                  over_range_mask, input ready);
  modport sink (input valid, filtered_force_x, filtered_force_y, filtered_force_z,
                filtered_torque_x, filtered_torque_y, filtered_torque_z,
                over_range_mask, output ready);
endinterface

`default_nettype wire

FILE: hdl/sks_regs.sv
// ----------------------------------------------------------------------------
// sks_regs
// APB configuration registers: enable, limits and offset pairs.
// ----------------------------------------------------------------------------
`default_nettype none

module sks_regs (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [sks_pkg::ADDR_W-1:0] paddr,
  input  wire logic [sks_pkg::DATA_W-1:0] pwdata,
  output logic      [sks_pkg::DATA_W-1:0] prdata,
  output logic                           pready,
  output sks_pkg::sks_cfg_t              cfg
);
  import sks_pkg::*;

  logic        enable;
  logic [30:0] force_limit;
  logic [30:0] torque_limit;
  logic [63:0] off_a;
  logic [63:0] off_b;
  logic [63:0] off_c;
  logic [2:0]  idx;
  logic        wr;

  assign pready = 1'b1;
  assign idx    = paddr[5:3];
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable       <= 1'b0;
      force_limit  <= 31'h7FFF_FFFF;
      torque_limit <= 31'h7FFF_FFFF;
      off_a        <= '0;
      off_b        <= '0;
      off_c        <= '0;
    end else if (wr) begin
      case (idx)
        REG_ENABLE:   enable       <= pwdata[0];
        REG_FLIMIT:   force_limit  <= pwdata[30:0];
        REG_TLIMIT:   torque_limit <= pwdata[30:0];
        REG_OFF_FXFY: off_a        <= pwdata;
        REG_OFF_FZTX: off_b        <= pwdata;
        REG_OFF_TYTZ: off_c        <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ENABLE:   prdata = {63'd0, enable};
      REG_FLIMIT:   prdata = {33'd0, force_limit};
      REG_TLIMIT:   prdata = {33'd0, torque_limit};
      REG_OFF_FXFY: prdata = off_a;
      REG_OFF_FZTX: prdata = off_b;
      REG_OFF_TYTZ: prdata = off_c;
      default:      prdata = '0;
    endcase
  end

  assign cfg.enable       = enable;
  assign cfg.force_limit  = force_limit;
  assign cfg.torque_limit = torque_limit;
  assign cfg.offset       = {off_c, off_b, off_a};

endmodule

`default_nettype wire

FILE: hdl/sks_ctrl.sv
// ----------------------------------------------------------------------------
// sks_ctrl
// Sequencer: walks the six channels through divide, multiply and update, or skips them when disabled.
// ----------------------------------------------------------------------------
`default_nettype none

module sks_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              enable,
  input  wire logic              out_free,
  output sks_pkg::sks_cmd_t      cmd
);
  import sks_pkg::*;

  sks_state_t       state, state_next;
  logic [CH_W-1:0]  ch, ch_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ch    <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      ch    <= ch_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    ch_next    = ch;
    cnt_next   = cnt;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          ch_next    = '0;
          state_next = enable ? ST_PREP : ST_DONE;
        end
      end
      ST_PREP: begin
        cnt_next   = DIV_LAST;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cnt_next = cnt - 1'b1;
        if (cnt == '0) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL:  state_next = ST_EST;
      ST_EST:  state_next = ST_OUT;
      ST_OUT: begin
        if (ch == CH_LAST) begin
          state_next = ST_DONE;
        end else begin
          ch_next    = ch + 1'b1;
          state_next = ST_PREP;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.load     = (state == ST_IDLE) && in_valid;
    cmd.prep     = (state == ST_PREP);
    cmd.div_step = (state == ST_DIV);
    cmd.mul      = (state == ST_MUL);
    cmd.upd_est  = (state == ST_EST);
    cmd.upd_out  = (state == ST_OUT);
    cmd.out_load = (state == ST_DONE) && out_free;
    cmd.ch       = ch;
  end

endmodule

`default_nettype wire

FILE: hdl/sks_datapath.sv
// ----------------------------------------------------------------------------
// sks_datapath
// Per-channel Kalman arithmetic, filter state and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sks_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  sks_pkg::sks_cmd_t         cmd,
  input  sks_pkg::sks_cfg_t         cfg,
  sks_sample_if.sink                sample,
  sks_result_if.source              result,
  output logic                      out_free
);
  import sks_pkg::*;

  logic signed [SAMPLE_W-1:0] smp  [CHANNELS];
  logic signed [SAMPLE_W-1:0] res  [CHANNELS];
  logic signed [SAMPLE_W-1:0] est  [CHANNELS];
  logic        [31:0]         pvar [CHANNELS];
  logic        [CHANNELS-1:0] flags;

  logic [31:0]  pp;
  logic [32:0]  dvs;
  logic [32:0]  rem;
  logic [K_W-1:0] q;
  logic         neg;
  logic [31:0]  mag;
  logic [59:0]  plo;
  logic [31:0]  phi;
  logic [62:0]  pv;
  logic         out_valid;

  logic signed [SAMPLE_W-1:0] raw [CHANNELS];
  logic [CHANNELS-1:0] over;
  logic [31:0]  pp_c;
  logic [32:0]  dif;
  logic [33:0]  rem2;
  logic [63:0]  step_w;
  logic [32:0]  step;
  logic [32:0]  est_sum;
  logic [63:0]  pv_r;
  logic [32:0]  corr;
  logic signed [SAMPLE_W-1:0] off;
  logic signed [SAMPLE_W-1:0] sat;

  assign raw[0] = sample.force_x;
  assign raw[1] = sample.force_y;
  assign raw[2] = sample.force_z;
  assign raw[3] = sample.torque_x;
  assign raw[4] = sample.torque_y;
  assign raw[5] = sample.torque_z;
  assign sample.ready = cmd.load;

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      if (i < 3) begin
        over[i] = raw[i] > $signed({1'b0, cfg.force_limit});
      end else begin
        over[i] = raw[i] > $signed({1'b0, cfg.torque_limit});
      end
    end
  end

  assign pp_c    = pvar[cmd.ch] + PROC_NOISE;
  assign dif     = {smp[cmd.ch][SAMPLE_W-1], smp[cmd.ch]} - {est[cmd.ch][SAMPLE_W-1], est[cmd.ch]};
  assign rem2    = {rem, 1'b0};
  assign step_w  = 64'(phi) + ((64'(plo) + HALF_Q30) >> 30);
  assign step    = step_w[32:0];
  assign est_sum = neg ? ({est[cmd.ch][SAMPLE_W-1], est[cmd.ch]} - step)
                       : ({est[cmd.ch][SAMPLE_W-1], est[cmd.ch]} + step);
  assign pv_r    = (64'(pv) + HALF_Q30) >> 30;
  assign off     = cfg.offset[cmd.ch];
  assign corr    = {est[cmd.ch][SAMPLE_W-1], est[cmd.ch]} - {off[SAMPLE_W-1], off};

  always_comb begin
    if (corr[32] && !corr[31]) begin
      sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else if (!corr[32] && corr[31]) begin
      sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      sat = corr[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        est[i]  <= '0;
        pvar[i] <= VAR_RESET;
      end
    end else if (cmd.upd_est) begin
      est[cmd.ch]  <= est_sum[31:0];
      pvar[cmd.ch] <= pv_r[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < CHANNELS; i++) begin
        smp[i] <= raw[i];
        res[i] <= raw[i];
      end
      flags <= over;
    end
    if (cmd.prep) begin
      pp  <= pp_c;
      dvs <= {1'b0, pp_c} + 33'(meas_noise(cmd.ch));
      rem <= {1'b0, pp_c};
      q   <= '0;
      neg <= dif[32];
      mag <= dif[32] ? 32'(-dif) : dif[31:0];
    end
    if (cmd.div_step) begin
      if (rem2 >= {1'b0, dvs}) begin
        rem <= 33'(rem2 - {1'b0, dvs});
        q   <= {q[K_W-2:0], 1'b1};
      end else begin
        rem <= rem2[32:0];
        q   <= {q[K_W-2:0], 1'b0};
      end
    end
    if (cmd.mul) begin
      plo <= q * mag[29:0];
      phi <= 32'(q) * 32'(mag[31:30]);
      pv  <= (ONE_Q30 - {1'b0, q}) * pp;
    end
    if (cmd.upd_out) begin
      res[cmd.ch] <= sat;
    end
  end

  assign out_free = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.filtered_force_x  <= res[0];
      result.filtered_force_y  <= res[1];
      result.filtered_force_z  <= res[2];
      result.filtered_torque_x <= res[3];
      result.filtered_torque_y <= res[4];
      result.filtered_torque_z <= res[5];
      result.over_range_mask   <= flags;
    end
  end

  assign result.valid = out_valid;

endmodule

`default_nettype wire

FILE: hdl/six_axis_kalman_smoother_unit.sv
// ----------------------------------------------------------------------------
// six_axis_kalman_smoother_unit
// Six-axis force/torque smoother with per-channel scalar Kalman filters.
// ----------------------------------------------------------------------------
// Usage:
//   sample: valid/ready sink, one six-axis Q16.16 sample per transfer.
//   result: valid/ready source, six filtered samples plus over-range mask.
//   APB port: enable, force/torque limits and three offset pairs at 8*i.
//   Filter on: each channel passes in turn through prepare, a 30-step
//   restoring divide for the gain, multiply, estimate update and output.
//   Filter off: the raw sample goes straight to the output register.
//   One sample is in work at a time; the next is taken as soon as the
//   result moves to the output register, even while that result waits.
//   Receiver stall: the result register holds, and the sequencer waits at
//   its final step until the register frees.
//   Reset (rst, synchronous): estimates to 0, variances to 1.0, registers
//   to their defaults, no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module six_axis_kalman_smoother_unit (
  input  wire logic                       clk,
  input  wire logic                       rst,
  sks_sample_if.sink                      sample,
  sks_result_if.source                    result,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [sks_pkg::ADDR_W-1:0] paddr,
  input  wire logic [sks_pkg::DATA_W-1:0] pwdata,
  output logic      [sks_pkg::DATA_W-1:0] prdata,
  output logic                            pready
);
  import sks_pkg::*;

  sks_cfg_t cfg;
  sks_cmd_t cmd;
  logic     out_free;

  sks_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sks_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .enable   (cfg.enable),
    .out_free (out_free),
    .cmd      (cmd)
  );

  sks_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cfg      (cfg),
    .sample   (sample),
    .result   (result),
    .out_free (out_free)
  );

endmodule

`default_nettype wire
